[rtl/core/atilt_pkg.sv]
// ----------------------------------------------------------------------------
// atilt_pkg
// Shared widths, constants, angle table and pipeline record types for the
// accelerometer tilt / roll / pitch core.
// ----------------------------------------------------------------------------
package atilt_pkg;

   localparam int SAMPLE_W      = 16;
   localparam int CORDIC_STAGES = 18;
   localparam int MAX_STAGES    = 30;
   localparam int FRAC_BITS     = (61 - 2 * SAMPLE_W) / 2;
   localparam int SQ_W          = 2 * SAMPLE_W;              // x*x + y*y
   localparam int RAD_W         = SQ_W + 2 * FRAC_BITS;      // sqrt radicand
   localparam int ROOT_W        = RAD_W / 2;
   localparam int REM_W         = ROOT_W + 2;
   localparam int CW            = SAMPLE_W + FRAC_BITS + 4;  // CORDIC x / y
   localparam int AW            = 40;                        // angle, 1e-9 deg
   localparam int NW            = AW;                        // |angle| + half unit
   localparam int QW            = 17;                        // quotient bits

   // reciprocal divide by the unit: (n / 4) * ceil(2^57 / 5^9) >> 57
   localparam int     RQ_W     = 36;                         // n / 4
   localparam int     RCP_K    = 57;
   localparam int     RCP_W    = 37;
   localparam int     RCP_LO_W = 19;
   localparam int     RCP_HI_W = RCP_W - RCP_LO_W;
   localparam longint RCP_M    = 64'd73786976295;
   localparam logic [RCP_LO_W-1:0] RCP_LO = RCP_LO_W'(RCP_M);
   localparam logic [RCP_HI_W-1:0] RCP_HI = RCP_HI_W'(RCP_M >> RCP_LO_W);
   localparam int     PL_W     = RQ_W + RCP_LO_W;
   localparam int     PH_W     = RQ_W + RCP_HI_W;
   localparam int     PS_W     = RCP_K + QW;

   localparam int TILT_W  = 15;
   localparam int ROLL_W  = 16;
   localparam int PITCH_W = 15;

   localparam int NUM_CH   = 3;
   localparam int CH_TILT  = 0;
   localparam int CH_ROLL  = 1;
   localparam int CH_PITCH = 2;

   localparam longint NANO       = 64'd1000000000;
   localparam longint UNIT_STEP  = NANO / 128;     // 1/128 deg in 1e-9 deg
   localparam longint UNIT_HALF  = UNIT_STEP / 2;

   localparam logic signed [AW-1:0] DEG90  = 40'sd90000000000;
   localparam logic signed [AW-1:0] DEG180 = 40'sd180000000000;

   // atan(2^-i) in units of 1e-9 degree
   localparam logic signed [AW-1:0] ATAN_TAB [0:MAX_STAGES-1] = '{
      40'sd45000000000, 40'sd26565051177, 40'sd14036243468, 40'sd7125016349,
      40'sd3576334375,  40'sd1789910608,  40'sd895173710,   40'sd447614171,
      40'sd223810500,   40'sd111905677,   40'sd55952892,    40'sd27976453,
      40'sd13988227,    40'sd6994114,     40'sd3497057,     40'sd1748528,
      40'sd874264,      40'sd437132,      40'sd218566,      40'sd109283,
      40'sd54642,       40'sd27321,       40'sd13660,       40'sd6830,
      40'sd3415,        40'sd1708,        40'sd854,         40'sd427,
      40'sd213,         40'sd107
   };

   // output clamp limits per channel
   localparam logic signed [QW:0] ANG_LO [0:NUM_CH-1] = '{
      (QW+1)'(0), (QW+1)'(-23040), (QW+1)'(-11520)
   };
   localparam logic signed [QW:0] ANG_HI [0:NUM_CH-1] = '{
      (QW+1)'(23040), (QW+1)'(23040), (QW+1)'(11520)
   };

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] x;
      logic signed [SAMPLE_W-1:0] y;
      logic signed [SAMPLE_W-1:0] z;
   } smp_type;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [RAD_W-1:0]  rad;
   } sq_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [AW-1:0] a;
      logic                 done;
   } cord_type;

   typedef struct packed {
      logic [RQ_W-1:0] n;
      logic            neg;
   } rnd_type;

   typedef struct packed {
      logic [PL_W-1:0] plo;
      logic [PH_W-1:0] phi;
      logic            neg;
   } prod_type;

   typedef struct packed {
      logic [QW-1:0] q;
      logic          neg;
   } div_type;

endpackage

[rtl/core/accel_tilt_angles_core.sv]
// ----------------------------------------------------------------------------
// accel_tilt_angles_core
// Tilt, roll and pitch angles (1/128 degree) from one three-axis
// accelerometer sample, fully pipelined sqrt + CORDIC + rounding.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | dir | handshake
//  --------+-----------------------------------------+-----+-----------------
//  request | req_accel_x / _y / _z                   | in  | req_valid/ready
//  result  | rsp_tilt_angle/_roll_angle/_pitch_angle | out | rsp_valid/ready
//
//  One item enters per cycle while the pipe advances; it then passes through
//  56 register stages: 1 capture, 1 square, 1 sum, 30 sqrt bit steps,
//  1 CORDIC setup, 18 CORDIC stages, 1 rounding setup, 1 reciprocal
//  multiply, 1 quotient add, 1 output.
//  The whole pipe advances together; it holds when the output item is
//  not taken, and bubbles travel as cleared valid bits.
//  Synchronous reset clears the valid bits only; payload is not reset.
//
module accel_tilt_angles_core
   import atilt_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_accel_x,
   input  logic signed [SAMPLE_W-1:0] req_accel_y,
   input  logic signed [SAMPLE_W-1:0] req_accel_z,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic        [TILT_W-1:0]   rsp_tilt_angle,
   output logic signed [ROLL_W-1:0]   rsp_roll_angle,
   output logic signed [PITCH_W-1:0]  rsp_pitch_angle
);

   // pipe advances when the output slot is free or being emptied
   logic adv;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;

   // ---------------- capture ----------------
   logic    in_v_ff;
   smp_type in_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (adv) begin
         in_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_ff.x <= req_accel_x;
         in_ff.y <= req_accel_y;
         in_ff.z <= req_accel_z;
      end
   end

   // ---------------- squares ----------------
   logic              mul_v_ff;
   smp_type           mul_smp_ff;
   logic [SQ_W-1:0]   xx_ff, yy_ff, zz_ff;
   logic signed [SQ_W-1:0] xx_in, yy_in, zz_in;

   assign xx_in = SQ_W'(in_ff.x) * SQ_W'(in_ff.x);
   assign yy_in = SQ_W'(in_ff.y) * SQ_W'(in_ff.y);
   assign zz_in = SQ_W'(in_ff.z) * SQ_W'(in_ff.z);

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_v_ff <= 1'b0;
      end else if (adv) begin
         mul_v_ff <= in_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mul_smp_ff <= in_ff;
         xx_ff      <= xx_in;
         yy_ff      <= yy_in;
         zz_ff      <= zz_in;
      end
   end

   // ---------------- sums, then bit-serial square roots ----------------
   // channel 0: sqrt(x^2+y^2), channel 1: sqrt(y^2+z^2), both scaled 2^F
   logic                sq_v_ff   [0:ROOT_W];
   smp_type             sq_smp_ff [0:ROOT_W];
   sq_type [1:0]        sq_ff     [0:ROOT_W];
   sq_type [1:0]        sq0_in;

   always_comb begin
      sq0_in[0].rem  = '0;
      sq0_in[0].root = '0;
      sq0_in[0].rad  = {SQ_W'(xx_ff + yy_ff), {(2*FRAC_BITS){1'b0}}};
      sq0_in[1].rem  = '0;
      sq0_in[1].root = '0;
      sq0_in[1].rad  = {SQ_W'(yy_ff + zz_ff), {(2*FRAC_BITS){1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_v_ff[0] <= mul_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_smp_ff[0] <= mul_smp_ff;
         sq_ff[0]     <= sq0_in;
      end
   end

   for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
      sq_type [1:0] sq_in;

      always_comb begin
         logic [REM_W+1:0] r2;
         logic [REM_W+1:0] trial;
         for (int c = 0; c < 2; c++) begin
            r2    = {sq_ff[j][c].rem, sq_ff[j][c].rad[RAD_W-1 -: 2]};
            trial = (REM_W+2)'({sq_ff[j][c].root, 2'b01});
            sq_in[c].rad = {sq_ff[j][c].rad[RAD_W-3:0], 2'b00};
            if (r2 >= trial) begin
               sq_in[c].rem  = REM_W'(r2 - trial);
               sq_in[c].root = {sq_ff[j][c].root[ROOT_W-2:0], 1'b1};
            end else begin
               sq_in[c].rem  = REM_W'(r2);
               sq_in[c].root = {sq_ff[j][c].root[ROOT_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[j+1] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[j+1] <= sq_v_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_smp_ff[j+1] <= sq_smp_ff[j];
            sq_ff[j+1]     <= sq_in;
         end
      end
   end

   // ---------------- CORDIC setup ----------------
   // atan2(Y, X) per channel; axis cases resolved here, left half plane
   // folded over with a +/-180 deg base angle.
   logic                    cd_v_ff [0:CORDIC_STAGES];
   cord_type [NUM_CH-1:0]   cd_ff   [0:CORDIC_STAGES];
   cord_type [NUM_CH-1:0]   cd0_in;
   logic signed [CW-1:0]    ay [NUM_CH];
   logic signed [CW-1:0]    ax [NUM_CH];
   logic signed [CW-1:0]    xs, ys, zs, sxy, syz;

   always_comb begin
      xs  = CW'(sq_smp_ff[ROOT_W].x) <<< FRAC_BITS;
      ys  = CW'(sq_smp_ff[ROOT_W].y) <<< FRAC_BITS;
      zs  = CW'(sq_smp_ff[ROOT_W].z) <<< FRAC_BITS;
      sxy = $signed({{(CW-ROOT_W){1'b0}}, sq_ff[ROOT_W][0].root});
      syz = $signed({{(CW-ROOT_W){1'b0}}, sq_ff[ROOT_W][1].root});

      ay[CH_TILT]  = sxy;
      ax[CH_TILT]  = -zs;
      ay[CH_ROLL]  = -ys;
      ax[CH_ROLL]  = -zs;
      ay[CH_PITCH] = -xs;
      ax[CH_PITCH] = syz;

      for (int c = 0; c < NUM_CH; c++) begin
         priority if (ay[c] == '0) begin
            cd0_in[c].done = 1'b1;
            cd0_in[c].a    = (ax[c] < 0) ? DEG180 : '0;
            cd0_in[c].x    = ax[c];
            cd0_in[c].y    = ay[c];
         end else if (ax[c] == '0) begin
            cd0_in[c].done = 1'b1;
            cd0_in[c].a    = (ay[c] > 0) ? DEG90 : -DEG90;
            cd0_in[c].x    = ax[c];
            cd0_in[c].y    = ay[c];
         end else if (ax[c] < 0) begin
            cd0_in[c].done = 1'b0;
            cd0_in[c].a    = (ay[c] > 0) ? DEG180 : -DEG180;
            cd0_in[c].x    = -ax[c];
            cd0_in[c].y    = -ay[c];
         end else begin
            cd0_in[c].done = 1'b0;
            cd0_in[c].a    = '0;
            cd0_in[c].x    = ax[c];
            cd0_in[c].y    = ay[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cd_v_ff[0] <= 1'b0;
      end else if (adv) begin
         cd_v_ff[0] <= sq_v_ff[ROOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cd_ff[0] <= cd0_in;
      end
   end

   // ---------------- CORDIC vectoring, one micro-rotation per stage ----------
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      cord_type [NUM_CH-1:0] cd_in;

      always_comb begin
         for (int c = 0; c < NUM_CH; c++) begin
            cd_in[c] = cd_ff[i][c];
            if (!cd_ff[i][c].done) begin
               if (cd_ff[i][c].y > 0) begin
                  cd_in[c].x = cd_ff[i][c].x + (cd_ff[i][c].y >>> i);
                  cd_in[c].y = cd_ff[i][c].y - (cd_ff[i][c].x >>> i);
                  cd_in[c].a = cd_ff[i][c].a + ATAN_TAB[i];
               end else begin
                  cd_in[c].x = cd_ff[i][c].x - (cd_ff[i][c].y >>> i);
                  cd_in[c].y = cd_ff[i][c].y + (cd_ff[i][c].x >>> i);
                  cd_in[c].a = cd_ff[i][c].a - ATAN_TAB[i];
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cd_v_ff[i+1] <= 1'b0;
         end else if (adv) begin
            cd_v_ff[i+1] <= cd_v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cd_ff[i+1] <= cd_in;
         end
      end
   end

   // ---------------- rounding: (|a| + half unit) / unit ----------------
   // unit = 7812500 = 4 * 5^9: drop two bits, then multiply by the
   // reciprocal ceil(2^57 / 5^9); exact over the whole angle range
   logic                 rn_v_ff;
   rnd_type [NUM_CH-1:0] rn_ff;
   rnd_type [NUM_CH-1:0] rn_in;

   always_comb begin
      logic signed [AW-1:0] a;
      logic        [NW-1:0] n;
      for (int c = 0; c < NUM_CH; c++) begin
         a            = cd_ff[CORDIC_STAGES][c].a;
         rn_in[c].neg = (a < 0);
         n            = NW'(rn_in[c].neg ? -a : a) + NW'(UNIT_HALF);
         rn_in[c].n   = n[RQ_W+1:2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rn_v_ff <= 1'b0;
      end else if (adv) begin
         rn_v_ff <= cd_v_ff[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rn_ff <= rn_in;
      end
   end

   // reciprocal split in two constant partial products
   logic                  pr_v_ff;
   prod_type [NUM_CH-1:0] pr_ff;
   prod_type [NUM_CH-1:0] pr_in;

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         pr_in[c].neg = rn_ff[c].neg;
         pr_in[c].plo = PL_W'(rn_ff[c].n) * PL_W'(RCP_LO);
         pr_in[c].phi = PH_W'(rn_ff[c].n) * PH_W'(RCP_HI);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_v_ff <= 1'b0;
      end else if (adv) begin
         pr_v_ff <= rn_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pr_ff <= pr_in;
      end
   end

   // recombine, quotient is the top bits
   logic                 dv_v_ff;
   div_type [NUM_CH-1:0] dv_ff;
   div_type [NUM_CH-1:0] dv_in;

   always_comb begin
      logic [PS_W-1:0] sum;
      for (int c = 0; c < NUM_CH; c++) begin
         sum          = (PS_W'(pr_ff[c].phi) << RCP_LO_W) + PS_W'(pr_ff[c].plo);
         dv_in[c].neg = pr_ff[c].neg;
         dv_in[c].q   = sum[PS_W-1 -: QW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff <= 1'b0;
      end else if (adv) begin
         dv_v_ff <= pr_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ff <= dv_in;
      end
   end

   // ---------------- sign, clamp, output register ----------------
   logic signed [QW:0] ang [NUM_CH];
   logic signed [QW:0] mag;

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         mag    = $signed({1'b0, dv_ff[c].q});
         ang[c] = dv_ff[c].neg ? -mag : mag;
         if (ang[c] < ANG_LO[c]) begin
            ang[c] = ANG_LO[c];
         end else if (ang[c] > ANG_HI[c]) begin
            ang[c] = ANG_HI[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tilt_angle  <= ang[CH_TILT][TILT_W-1:0];
         rsp_roll_angle  <= ang[CH_ROLL][ROLL_W-1:0];
         rsp_pitch_angle <= ang[CH_PITCH][PITCH_W-1:0];
      end
   end

`ifndef SYNTHESIS
   a_tilt_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_tilt_angle <= TILT_W'(23040))
      else $error("tilt angle out of range");

   a_roll_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_roll_angle <= 16'sd23040) && (rsp_roll_angle >= -16'sd23040))
      else $error("roll angle out of range");

   a_pitch_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_angle <= 15'sd11520) && (rsp_pitch_angle >= -15'sd11520))
      else $error("pitch angle out of range");
`endif

endmodule

[tb/tb_accel_tilt_angles_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_accel_tilt_angles_core
// Streams accelerometer samples through the tilt / roll / pitch core under
// random valid and ready gaps. Each accepted sample gets its three angles
// predicted by an in-bench fixed-point model (integer sqrt + CORDIC +
// rounding). Every result item is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_accel_tilt_angles_core
   import atilt_pkg::*;
();

   localparam int N_RANDOM = 1430;
   localparam int DRAIN    = 150;     // covers the pipe depth, plus slack

   typedef struct {
      logic signed [SAMPLE_W-1:0] x;
      logic signed [SAMPLE_W-1:0] y;
      logic signed [SAMPLE_W-1:0] z;
   } sample_type;

   typedef struct {
      logic        [TILT_W-1:0]  tilt;
      logic signed [ROLL_W-1:0]  roll;
      logic signed [PITCH_W-1:0] pitch;
   } angles_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_accel_x;
   logic signed [SAMPLE_W-1:0] req_accel_y;
   logic signed [SAMPLE_W-1:0] req_accel_z;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic        [TILT_W-1:0]   rsp_tilt_angle;
   logic signed [ROLL_W-1:0]   rsp_roll_angle;
   logic signed [PITCH_W-1:0]  rsp_pitch_angle;

   sample_type sample_q[$];    // items waiting to be driven
   angles_type angle_q[$];     // predicted angles, oldest first
   int      n_total;
   int      n_accepted;
   int      n_checked;
   int      n_errors;
   int      send_idle_pct;
   int      recv_idle_pct;

   accel_tilt_angles_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_accel_x     (req_accel_x),
      .req_accel_y     (req_accel_y),
      .req_accel_z     (req_accel_z),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_tilt_angle  (rsp_tilt_angle),
      .rsp_roll_angle  (rsp_roll_angle),
      .rsp_pitch_angle (rsp_pitch_angle)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // ---------------------------------------------------------------- model
   // floor integer square root, bit-pair method
   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // atan2(yy, xx) in 1e-9 degree, vectoring CORDIC with exact axis cases
   function automatic longint atan2_nano(longint yy, longint xx);
      longint base, acc, dx, dy, step;
      base = 0;
      acc  = 0;
      if (yy == 0) return (xx < 0) ? longint'(DEG180) : 0;
      if (xx == 0) return (yy > 0) ? longint'(DEG90) : -longint'(DEG90);
      if (xx < 0) begin
         base = (yy > 0) ? longint'(DEG180) : -longint'(DEG180);
         xx = -xx;
         yy = -yy;
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         dx   = yy >>> i;     // arithmetic shift = floor
         dy   = xx >>> i;
         step = longint'(ATAN_TAB[i]);
         if (yy > 0) begin
            xx  = xx + dx;
            yy  = yy - dy;
            acc = acc + step;
         end else begin
            xx  = xx - dx;
            yy  = yy + dy;
            acc = acc - step;
         end
      end
      return base + acc;
   endfunction

   // round half away from zero to 1/128 degree, then clamp
   function automatic longint nano_to_units(longint a, longint lo, longint hi);
      longint m, q;
      m = (a < 0) ? -a : a;
      q = (m * 128 + NANO / 2) / NANO;
      if (a < 0) q = -q;
      if (q < lo) q = lo;
      if (q > hi) q = hi;
      return q;
   endfunction

   function automatic angles_type compute_angles(sample_type s);
      angles_type      r;
      longint          x, y, z, sxy, syz;
      longint unsigned sq;
      x   = s.x;
      y   = s.y;
      z   = s.z;
      sq  = longint'(x * x + y * y);
      sxy = root_floor(sq << (2 * FRAC_BITS));
      sq  = longint'(y * y + z * z);
      syz = root_floor(sq << (2 * FRAC_BITS));
      x   = x <<< FRAC_BITS;
      y   = y <<< FRAC_BITS;
      z   = z <<< FRAC_BITS;
      r.tilt  = TILT_W'(nano_to_units(atan2_nano(sxy, -z), 0, 23040));
      r.roll  = ROLL_W'(nano_to_units(atan2_nano(-y, -z), -23040, 23040));
      r.pitch = PITCH_W'(nano_to_units(atan2_nano(-x, syz), -11520, 11520));
      return r;
   endfunction

   // ---------------------------------------------------------------- driver
   // idle mix follows progress: sender rarely idle / receiver often stalls,
   // then swapped, then full throughput
   always_comb begin
      if (n_accepted < n_total / 3) begin
         send_idle_pct = 9;
         recv_idle_pct = 78;
      end else if (n_accepted < (2 * n_total) / 3) begin
         send_idle_pct = 78;
         recv_idle_pct = 9;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         if (req_valid && req_ready) begin
            angle_q.push_back(compute_angles('{req_accel_x, req_accel_y, req_accel_z}));
            n_accepted <= n_accepted + 1;
         end
         // payload may change only when no item is pending
         if (!req_valid || req_ready) begin
            if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid   <= 1'b1;
               req_accel_x <= sample_q[0].x;
               req_accel_y <= sample_q[0].y;
               req_accel_z <= sample_q[0].z;
               void'(sample_q.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // --------------------------------------------------------------- monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (angle_q.size() == 0) begin
            $display("%0t: unexpected result item tilt=%0d roll=%0d pitch=%0d",
                     $time, rsp_tilt_angle, rsp_roll_angle, rsp_pitch_angle);
            n_errors++;
         end else begin
            if (rsp_tilt_angle !== angle_q[0].tilt) begin
               $display("%0t: tilt expected %0d actual %0d",
                        $time, angle_q[0].tilt, rsp_tilt_angle);
               n_errors++;
            end
            if (rsp_roll_angle !== angle_q[0].roll) begin
               $display("%0t: roll expected %0d actual %0d",
                        $time, angle_q[0].roll, rsp_roll_angle);
               n_errors++;
            end
            if (rsp_pitch_angle !== angle_q[0].pitch) begin
               $display("%0t: pitch expected %0d actual %0d",
                        $time, angle_q[0].pitch, rsp_pitch_angle);
               n_errors++;
            end
            void'(angle_q.pop_front());
            n_checked++;
         end
      end
   end

   // ------------------------------------------------------------- stimulus
   function automatic logic signed [SAMPLE_W-1:0] pick_axis();
      case ($urandom_range(9))
         0:       return '0;
         1, 2, 3: return SAMPLE_W'(int'($urandom_range(33000)) - 16500); // ~1 g
         4:       return SAMPLE_W'(int'($urandom_range(64)) - 32);       // near zero
         5:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   initial begin
      sample_type s;
      reset       = 1'b1;
      req_valid   = 1'b0;
      rsp_ready   = 1'b0;
      req_accel_x = '0;
      req_accel_y = '0;
      req_accel_z = '0;
      n_accepted  = 0;
      n_checked   = 0;
      n_errors    = 0;

      // directed: all zero, each axis alone at both signs and at negative
      // full scale, exact 90 / 180 degree cases, full-scale corners
      sample_q.push_back('{16'sd0,      16'sd0,      16'sd0});
      sample_q.push_back('{16'sd0,      16'sd0,      16'sd16384});
      sample_q.push_back('{16'sd0,      16'sd0,     -16'sd16384});
      sample_q.push_back('{16'sd0,      16'sd16384,  16'sd0});
      sample_q.push_back('{16'sd0,     -16'sd16384,  16'sd0});
      sample_q.push_back('{16'sd16384,  16'sd0,      16'sd0});
      sample_q.push_back('{-16'sd16384, 16'sd0,      16'sd0});
      sample_q.push_back('{16'sh7fff,   16'sh7fff,   16'sh7fff});
      sample_q.push_back('{16'sh8000,   16'sh8000,   16'sh8000});
      sample_q.push_back('{16'sh7fff,   16'sh8000,   16'sh7fff});
      sample_q.push_back('{16'sh8000,   16'sh7fff,   16'sh8000});
      sample_q.push_back('{16'sh8000,   16'sd0,      16'sd0});
      sample_q.push_back('{16'sd0,      16'sh8000,   16'sd0});
      sample_q.push_back('{16'sd0,      16'sd0,      16'sh8000});
      sample_q.push_back('{16'sd0,      16'sd0,      16'sh7fff});
      sample_q.push_back('{16'sd1,      16'sd0,      16'sd0});
      sample_q.push_back('{16'sd0,     -16'sd1,      16'sd0});
      sample_q.push_back('{16'sd0,      16'sd0,     -16'sd1});
      sample_q.push_back('{16'sd1,      16'sd1,      16'sd1});
      sample_q.push_back('{-16'sd1,    -16'sd1,     -16'sd1});
      sample_q.push_back('{16'sd100,    16'sd200,   -16'sd16000});
      sample_q.push_back('{16'sd11585,  16'sd0,     -16'sd11585});
      for (int i = 0; i < N_RANDOM; i++) begin
         s.x = pick_axis();
         s.y = pick_axis();
         s.z = pick_axis();
         sample_q.push_back(s);
      end
      n_total = sample_q.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (!(n_accepted == n_total && angle_q.size() == 0)) begin
         @(posedge clock);
      end
      repeat (DRAIN) @(posedge clock);

      $display("checked %0d of %0d samples: directed axis and full-scale cases,",
               n_checked, n_total);
      $display("then random samples under sender-idle, receiver-stall and back-to-back traffic");
      if (n_errors == 0 && angle_q.size() == 0) begin
         $display("accel_tilt_angles_core: match");
      end else begin
         $display("accel_tilt_angles_core: mismatch");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #3000000;
      $display("timeout with %0d results outstanding", angle_q.size());
      $display("accel_tilt_angles_core: mismatch");
      $finish;
   end

endmodule
